// ----- src/krt_pkg.sv -----
// Package for the keyed record table: field widths, operation and status codes,
// and the default parameter values. No dependencies.

package krt_pkg;

  localparam int KEY_W = 31;
  localparam int PAY_IO_W = 32;
  localparam int CNT_W = 5;

  localparam int DEF_CAPACITY = 16;
  localparam int DEF_PAYLOAD_WIDTH = 32;

  typedef enum logic [1:0] {
    FUNC_ADD     = 2'd0,
    FUNC_GET     = 2'd1,
    FUNC_REMOVE  = 2'd2,
    FUNC_COMPACT = 2'd3
  } krt_func_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } krt_mem_ctl_t;

endpackage

// ----- src/krt_mem.sv -----
// Entry memory of the keyed record table: one write port and one read port
// with registered read data. Depends on krt_pkg for the port control struct.

module krt_mem import krt_pkg::*; #(
  parameter int DEPTH = DEF_CAPACITY,
  parameter int WORD_W = KEY_W + DEF_PAYLOAD_WIDTH + 1
) (
  input  logic                     clk,
  input  krt_mem_ctl_t             ctl,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WORD_W-1:0]        wr_data,
  output logic [WORD_W-1:0]        rd_data
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/keyed_record_table_with_tombstones.sv -----
// Top level of the keyed record table: command sequencer, fill and live counters
// and result registers. Depends on krt_pkg and instantiates krt_mem.
//
// Usage: an item (in_func, in_key, in_payload) is taken at a rising edge where
// start is high and busy is low. Add overwrites the live record with the same
// key or appends one at the fill level, get returns a payload, remove marks a
// record as a tombstone and compact squeezes tombstones out in order.
// Each item gives one result, shown for exactly one cycle with out_strobe high,
// carrying the status, the payload found and the live, tombstone and fill counts.
// The receiver cannot stall; the result registers simply hold each result for
// its single cycle while the next item may already be accepted.
// Timing: the entries below the fill level are read one per cycle through the
// single read port of the entry memory, whose read data is registered. An item
// keeps busy high until the scan of its entries ends, earlier when a key search
// hits, and its result strobes in the first cycle with busy low.
// Reset (rst_n low, synchronous) empties the table and clears the counters;
// memory contents are not cleared, since only entries below the fill level
// are ever read.

module keyed_record_table_with_tombstones import krt_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_func,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [PAY_IO_W-1:0] in_payload,
  output logic                out_strobe,
  output logic [1:0]          out_status,
  output logic [PAY_IO_W-1:0] out_found_payload,
  output logic [CNT_W-1:0]    out_valid_count,
  output logic [CNT_W-1:0]    out_empty_count,
  output logic [CNT_W-1:0]    out_used_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WORD_W = KEY_W + PAYLOAD_WIDTH + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PACK
  } state_t;

  state_t                   state_r, state_nxt;
  krt_func_t                func_r, func_nxt;
  logic [KEY_W-1:0]         key_r, key_nxt;
  logic [PAYLOAD_WIDTH-1:0] pay_r, pay_nxt;
  logic [CW-1:0]            fill_r, fill_nxt;
  logic [CW-1:0]            live_r, live_nxt;
  logic [CW-1:0]            issue_idx_r, issue_idx_nxt;
  logic [CW-1:0]            pack_idx_r, pack_idx_nxt;
  logic [AW-1:0]            pend_idx_r, pend_idx_nxt;
  logic                     pend_r, pend_nxt;
  logic                     strobe_r, strobe_nxt;
  logic [1:0]               status_r, status_nxt;
  logic [PAY_IO_W-1:0]      found_r, found_nxt;
  logic [CNT_W-1:0]         valid_cnt_r, valid_cnt_nxt;
  logic [CNT_W-1:0]         empty_cnt_r, empty_cnt_nxt;
  logic [CNT_W-1:0]         used_cnt_r, used_cnt_nxt;

  krt_mem_ctl_t             mem_ctl;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            wr_addr;
  logic [WORD_W-1:0]        wr_data;
  logic [WORD_W-1:0]        rd_data;

  logic [KEY_W-1:0]         rd_key;
  logic [PAYLOAD_WIDTH-1:0] rd_pay;
  logic                     rd_dead;
  logic                     issue;
  logic                     hit;
  logic                     finish;

  krt_mem #(
    .DEPTH (CAPACITY),
    .WORD_W(WORD_W)
  ) u_mem (
    .clk    (clk),
    .ctl    (mem_ctl),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_data(rd_data)
  );

  assign rd_key  = rd_data[WORD_W-1 -: KEY_W];
  assign rd_pay  = rd_data[PAYLOAD_WIDTH:1];
  assign rd_dead = rd_data[0];

  assign issue   = (state_r != S_IDLE) && (issue_idx_r < fill_r);
  assign rd_addr = issue_idx_r[AW-1:0];
  assign hit     = pend_r && !rd_dead && (rd_key == key_r);
  assign finish  = !pend_r && !issue;
  assign busy    = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    key_nxt       = key_r;
    pay_nxt       = pay_r;
    fill_nxt      = fill_r;
    live_nxt      = live_r;
    issue_idx_nxt = issue_idx_r;
    pack_idx_nxt  = pack_idx_r;
    pend_idx_nxt  = pend_idx_r;
    pend_nxt      = 1'b0;
    strobe_nxt    = 1'b0;
    status_nxt    = status_r;
    found_nxt     = found_r;
    mem_ctl.rd_en = issue;
    mem_ctl.wr_en = 1'b0;
    wr_addr       = pend_idx_r;
    wr_data       = {key_r, pay_r, 1'b0};

    if (issue) begin
      issue_idx_nxt = issue_idx_r + CW'(1);
      pend_idx_nxt  = issue_idx_r[AW-1:0];
      pend_nxt      = 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt      = krt_func_t'(in_func);
          key_nxt       = in_key;
          pay_nxt       = PAYLOAD_WIDTH'(in_payload);
          issue_idx_nxt = '0;
          pack_idx_nxt  = '0;
          state_nxt     = (krt_func_t'(in_func) == FUNC_COMPACT) ? S_PACK : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit || finish) begin
          state_nxt  = S_IDLE;
          pend_nxt   = 1'b0;
          strobe_nxt = 1'b1;
          status_nxt = ST_OK;
          found_nxt  = '0;
          unique case (func_r)
            FUNC_ADD: begin
              if (hit) begin
                mem_ctl.wr_en = 1'b1;
              end else if (fill_r < CW'(CAPACITY)) begin
                mem_ctl.wr_en = 1'b1;
                wr_addr       = fill_r[AW-1:0];
                fill_nxt      = fill_r + CW'(1);
                live_nxt      = live_r + CW'(1);
              end else begin
                status_nxt = ST_FULL;
              end
            end
            FUNC_GET: begin
              if (hit) begin
                found_nxt = PAY_IO_W'(rd_pay);
              end else begin
                status_nxt = ST_NOT_FOUND;
              end
            end
            FUNC_REMOVE: begin
              if (hit) begin
                mem_ctl.wr_en = 1'b1;
                wr_data       = {key_r, rd_pay, 1'b1};
                live_nxt      = live_r - CW'(1);
              end else begin
                status_nxt = ST_NOT_FOUND;
              end
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_PACK: begin
        if (pend_r && !rd_dead) begin
          mem_ctl.wr_en = 1'b1;
          wr_addr       = pack_idx_r[AW-1:0];
          wr_data       = {rd_key, rd_pay, 1'b0};
          pack_idx_nxt  = pack_idx_r + CW'(1);
        end
        if (finish) begin
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
          status_nxt = ST_OK;
          found_nxt  = '0;
          fill_nxt   = pack_idx_r;
          live_nxt   = pack_idx_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    valid_cnt_nxt = CNT_W'(live_nxt);
    empty_cnt_nxt = CNT_W'(fill_nxt - live_nxt);
    used_cnt_nxt  = CNT_W'(fill_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      live_r      <= '0;
      pend_r      <= 1'b0;
      strobe_r    <= 1'b0;
      issue_idx_r <= '0;
      pack_idx_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      live_r      <= live_nxt;
      pend_r      <= pend_nxt;
      strobe_r    <= strobe_nxt;
      issue_idx_r <= issue_idx_nxt;
      pack_idx_r  <= pack_idx_nxt;
    end
    func_r      <= func_nxt;
    key_r       <= key_nxt;
    pay_r       <= pay_nxt;
    pend_idx_r  <= pend_idx_nxt;
    status_r    <= status_nxt;
    found_r     <= found_nxt;
    valid_cnt_r <= valid_cnt_nxt;
    empty_cnt_r <= empty_cnt_nxt;
    used_cnt_r  <= used_cnt_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_found_payload = found_r;
  assign out_valid_count   = valid_cnt_r;
  assign out_empty_count   = empty_cnt_r;
  assign out_used_count    = used_cnt_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("Result strobe while the sequencer is still busy.");

  a_counts_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= CW'(CAPACITY)) && (live_r <= fill_r))
    else $error("Fill or live count out of range.");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("Accepted item did not raise busy.");

  a_pack_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PACK && mem_ctl.wr_en) |-> (pack_idx_r <= CW'(pend_idx_r)))
    else $error("Compaction write overtook the entry being read.");

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for keyed_record_table_with_tombstones: directed and random
// add, get, remove and compact items checked against a behavioral table model.
// Depends on krt_pkg and the keyed_record_table_with_tombstones RTL.
`timescale 1ns / 100ps

module tb;
  import krt_pkg::*;

  localparam int CAP = DEF_CAPACITY;
  localparam int POOL_SIZE = 20;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 24;

  typedef struct {
    logic [1:0]          status;
    logic [PAY_IO_W-1:0] found;
    logic [CNT_W-1:0]    valid;
    logic [CNT_W-1:0]    empty;
    logic [CNT_W-1:0]    used;
  } table_result_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [1:0]          in_func;
  logic [KEY_W-1:0]    in_key;
  logic [PAY_IO_W-1:0] in_payload;
  logic                out_strobe;
  logic [1:0]          out_status;
  logic [PAY_IO_W-1:0] out_found_payload;
  logic [CNT_W-1:0]    out_valid_count;
  logic [CNT_W-1:0]    out_empty_count;
  logic [CNT_W-1:0]    out_used_count;

  logic [KEY_W-1:0]    rec_key [CAP];
  logic [PAY_IO_W-1:0] rec_pay [CAP];
  logic                rec_dead [CAP];
  int                  rec_fill;
  int                  rec_live;

  table_result_t       pending_results[$];
  int                  error_count;
  int                  idle_pct;
  int                  quiet_cycles;

  keyed_record_table_with_tombstones dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_func(in_func),
    .in_key(in_key),
    .in_payload(in_payload),
    .out_strobe(out_strobe),
    .out_status(out_status),
    .out_found_payload(out_found_payload),
    .out_valid_count(out_valid_count),
    .out_empty_count(out_empty_count),
    .out_used_count(out_used_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic table_result_t apply_table_op(krt_func_t op, logic [KEY_W-1:0] key,
                                                   logic [PAY_IO_W-1:0] pay);
    table_result_t r;
    int hit;
    int j;
    r.status = ST_OK;
    r.found = '0;
    hit = -1;
    for (int i = 0; i < rec_fill; i++) begin
      if (hit < 0 && !rec_dead[i] && rec_key[i] == key) hit = i;
    end
    case (op)
      FUNC_ADD: begin
        if (hit >= 0) begin
          rec_pay[hit] = pay;
        end else if (rec_fill < CAP) begin
          rec_key[rec_fill] = key;
          rec_pay[rec_fill] = pay;
          rec_dead[rec_fill] = 1'b0;
          rec_fill++;
          rec_live++;
        end else begin
          r.status = ST_FULL;
        end
      end
      FUNC_GET: begin
        if (hit >= 0) r.found = rec_pay[hit];
        else r.status = ST_NOT_FOUND;
      end
      FUNC_REMOVE: begin
        if (hit >= 0) begin
          rec_dead[hit] = 1'b1;
          rec_live--;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      default: begin
        j = 0;
        for (int i = 0; i < rec_fill; i++) begin
          if (!rec_dead[i]) begin
            rec_key[j] = rec_key[i];
            rec_pay[j] = rec_pay[i];
            rec_dead[j] = 1'b0;
            j++;
          end
        end
        rec_fill = j;
        rec_live = j;
      end
    endcase
    r.valid = CNT_W'(rec_live);
    r.empty = CNT_W'(rec_fill - rec_live);
    r.used = CNT_W'(rec_fill);
    return r;
  endfunction

  // Called in the time step of a rising edge; returns in the step of the accepting edge.
  task automatic send_item(krt_func_t op, logic [KEY_W-1:0] key, logic [PAY_IO_W-1:0] pay);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    in_func <= op;
    in_key <= key;
    in_payload <= pay;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(apply_table_op(op, key, pay));
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [PAY_IO_W-1:0] expected,
                             logic [PAY_IO_W-1:0] actual);
    if (expected !== actual) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expected, actual);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    table_result_t exp_r;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0h", $time,
                 out_status);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", PAY_IO_W'(exp_r.status), PAY_IO_W'(out_status));
        check_field("found_payload", exp_r.found, out_found_payload);
        check_field("valid_count", PAY_IO_W'(exp_r.valid), PAY_IO_W'(out_valid_count));
        check_field("empty_count", PAY_IO_W'(exp_r.empty), PAY_IO_W'(out_empty_count));
        check_field("used_count", PAY_IO_W'(exp_r.used), PAY_IO_W'(out_used_count));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_strobe === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[keyed_record_table_with_tombstones] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_empty_table();
    send_item(FUNC_GET, KEY_W'(5), 32'h1234_5678);
    send_item(FUNC_REMOVE, KEY_W'(5), 32'h0);
  endtask

  task automatic test_record_extremes();
    send_item(FUNC_ADD, '0, '0);
    send_item(FUNC_ADD, '1, '1);
    send_item(FUNC_GET, '1, '0);
    send_item(FUNC_ADD, '1, 32'hA5A5_5A5A);
    send_item(FUNC_REMOVE, '0, '1);
    send_item(FUNC_GET, '0, '0);
    send_item(FUNC_ADD, '0, 32'h8000_0001);
  endtask

  // A tombstoned entry still takes a slot, so the table fills before 16 live records.
  task automatic test_full_table();
    for (int i = 0; i < CAP - 3; i++) begin
      send_item(FUNC_ADD, KEY_W'(32'h100 + i), $urandom);
    end
    send_item(FUNC_ADD, KEY_W'(32'h7FFF_0000), $urandom);
    send_item(FUNC_COMPACT, KEY_W'($urandom), $urandom);
  endtask

  task automatic test_random_traffic(int pct, int count, bit drain_midway);
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int               sel;
    krt_func_t        op;
    logic [KEY_W-1:0] key;
    idle_pct = pct;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 40) op = FUNC_ADD;
      else if (sel < 65) op = FUNC_GET;
      else if (sel < 90) op = FUNC_REMOVE;
      else op = FUNC_COMPACT;
      if ($urandom_range(9) == 0) key = KEY_W'($urandom);
      else key = key_pool[$urandom_range(POOL_SIZE - 1)];
      send_item(op, key, $urandom);
      if (drain_midway && n == count / 2) wait_for_results();
    end
  endtask

  initial begin
    error_count = 0;
    idle_pct = 0;
    quiet_cycles = 0;
    rec_fill = 0;
    rec_live = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_func <= FUNC_ADD;
    in_key <= '0;
    in_payload <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_record_extremes();
    test_full_table();
    test_random_traffic(6, 135, 1'b1);
    test_random_traffic(74, 135, 1'b0);
    test_random_traffic(0, 135, 1'b0);
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[keyed_record_table_with_tombstones] OK");
    end else begin
      $display("[keyed_record_table_with_tombstones] ERROR");
    end
    $finish;
  end

endmodule
